/* hdl/lgrs_pkg.sv */
// Shared types and constants for the Life generation row stencil core.
// No dependencies; used by lgrs_stencil, lgrs_fifo and the top level.
package lgrs_pkg;

    localparam int ROW_W      = 64;  // cells carried per row
    localparam int IDX_W      = 6;   // row index width
    localparam int CNT_W      = 4;   // neighbor count and rule bound width
    localparam int ROWS_DEF   = 64;
    localparam int COLS_DEF   = 64;
    localparam int FIFO_DEPTH = 8;   // result queue, power of two, at least 4

    // configuration register indexes
    typedef logic [1:0] reg_addr_t;
    localparam reg_addr_t REG_SURVIVE_MIN = 2'd0;
    localparam reg_addr_t REG_SURVIVE_MAX = 2'd1;
    localparam reg_addr_t REG_BIRTH_MIN   = 2'd2;
    localparam reg_addr_t REG_BIRTH_MAX   = 2'd3;

    // rule reset values (standard B3/S23)
    localparam logic [CNT_W-1:0] SURVIVE_MIN_RST = 4'd2;
    localparam logic [CNT_W-1:0] SURVIVE_MAX_RST = 4'd3;
    localparam logic [CNT_W-1:0] BIRTH_MIN_RST   = 4'd3;
    localparam logic [CNT_W-1:0] BIRTH_MAX_RST   = 4'd3;

    typedef struct packed {
        logic [CNT_W-1:0] survive_min;
        logic [CNT_W-1:0] survive_max;
        logic [CNT_W-1:0] birth_min;
        logic [CNT_W-1:0] birth_max;
    } rule_t;

    // one result row
    typedef struct packed {
        logic             last;
        logic [IDX_W-1:0] row_index;
        logic [ROW_W-1:0] next_cells;
    } res_t;

    // up to two results pushed per cycle, first one first
    typedef struct packed {
        logic [1:0] count;
        res_t       first;
        res_t       second;
    } push_t;

endpackage

/* hdl/lgrs_stencil.sv */
// Per-column 3x3 neighbor count and rule compare for one row.
// Depends on lgrs_pkg (row width, rule struct).
module lgrs_stencil #(
    parameter int COLS = lgrs_pkg::COLS_DEF
) (
    input  logic [lgrs_pkg::ROW_W-1:0] above,
    input  logic [lgrs_pkg::ROW_W-1:0] mid,
    input  logic [lgrs_pkg::ROW_W-1:0] below,
    input  lgrs_pkg::rule_t            rule,
    output logic [lgrs_pkg::ROW_W-1:0] next_row
);

    localparam int W  = lgrs_pkg::ROW_W;
    localparam int CW = lgrs_pkg::CNT_W;

    for (genvar c = 0; c < W; c++) begin : g_lane
        if (c >= 1 && c + 1 < COLS && c < W - 1) begin : g_inner
            logic [CW-1:0] nb;
            assign nb = CW'(above[c-1]) + CW'(above[c]) + CW'(above[c+1])
                      + CW'(mid[c-1])                   + CW'(mid[c+1])
                      + CW'(below[c-1]) + CW'(below[c]) + CW'(below[c+1]);
            assign next_row[c] = mid[c]
                ? (nb >= rule.survive_min && nb <= rule.survive_max)
                : (nb >= rule.birth_min   && nb <= rule.birth_max);
        end else begin : g_border
            // border columns and columns past the grid stay dead
            assign next_row[c] = 1'b0;
        end
    end

endmodule

/* hdl/lgrs_fifo.sv */
// Result queue: takes up to two rows per cycle, hands out one.
// Depends on lgrs_pkg (res_t, push_t).
module lgrs_fifo #(
    parameter int DEPTH = lgrs_pkg::FIFO_DEPTH
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  lgrs_pkg::push_t            push,
    input  logic                       pop,
    output lgrs_pkg::res_t             head,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    lgrs_pkg::res_t mem_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PW'(push.count);
        rd_ptr_next = rd_ptr_reg + PW'(pop);
        count_next  = count_reg + CW'(push.count) - CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            mem_reg[wr_ptr_reg + PW'(1)] <= push.second;
        end
    end

    assign head  = mem_reg[rd_ptr_reg];
    assign count = count_reg;

endmodule

/* hdl/life_generation_row_stencil_core.sv */
// Life generation row stencil core: one automaton generation, one row per request.
// Throughput: one input row per cycle while s_tready is high, and results leave
// one per cycle while m_tready is high, each via the input register and the queue.
// The final row of a grid causes two results, absorbed by the result queue.
// Reset (aresetn low, synchronous): kept rows, row counter and queue clear,
// rules return to survive 2..3, birth 3..3.
module life_generation_row_stencil_core #(
    parameter int ROWS = lgrs_pkg::ROWS_DEF,  // 3..64
    parameter int COLS = lgrs_pkg::COLS_DEF   // 3..64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input rows
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,    // [63:0] row_cells
    // result rows
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,    // [63:0] next_cells, [69:64] row_index, [71:70] zero
    output logic        m_tlast,    // last
    // rule registers
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [3:0]  cfg_wdata
);

    localparam int W     = lgrs_pkg::ROW_W;
    localparam int IW    = lgrs_pkg::IDX_W;
    localparam int DEPTH = lgrs_pkg::FIFO_DEPTH;
    localparam int QCW   = $clog2(DEPTH + 1);

    localparam logic [IW-1:0] LAST_ROW = IW'(ROWS - 1);
    // bits at or above COLS are dropped on input
    localparam logic [W-1:0]  COL_MASK = (COLS >= W) ? {W{1'b1}}
                                                     : ((W'(1) << COLS) - W'(1));

    // ---------------------------------------------------------------
    // Rule registers
    // ---------------------------------------------------------------
    lgrs_pkg::rule_t rule_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rule_reg.survive_min <= lgrs_pkg::SURVIVE_MIN_RST;
            rule_reg.survive_max <= lgrs_pkg::SURVIVE_MAX_RST;
            rule_reg.birth_min   <= lgrs_pkg::BIRTH_MIN_RST;
            rule_reg.birth_max   <= lgrs_pkg::BIRTH_MAX_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                lgrs_pkg::REG_SURVIVE_MIN: rule_reg.survive_min <= cfg_wdata;
                lgrs_pkg::REG_SURVIVE_MAX: rule_reg.survive_max <= cfg_wdata;
                lgrs_pkg::REG_BIRTH_MIN:   rule_reg.birth_min   <= cfg_wdata;
                lgrs_pkg::REG_BIRTH_MAX:   rule_reg.birth_max   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Row window: the two rows before the current one, plus the index
    // of the next arriving row. Updated on every accepted request.
    // ---------------------------------------------------------------
    logic           in_fire;
    logic [W-1:0]   cur_row;
    logic [W-1:0]   row_two_back_reg, row_two_back_next;
    logic [W-1:0]   row_one_back_reg, row_one_back_next;
    logic [IW-1:0]  row_cnt_reg, row_cnt_next;

    assign in_fire = s_tvalid && s_tready;
    assign cur_row = s_tdata & COL_MASK;

    always_comb begin
        row_two_back_next = row_two_back_reg;
        row_one_back_next = row_one_back_reg;
        row_cnt_next      = row_cnt_reg;
        if (in_fire) begin
            if (row_cnt_reg == LAST_ROW) begin
                // grid done: next request starts a fresh generation
                row_two_back_next = '0;
                row_one_back_next = '0;
                row_cnt_next      = '0;
            end else begin
                row_two_back_next = row_one_back_reg;
                row_one_back_next = cur_row;
                row_cnt_next      = row_cnt_reg + IW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_two_back_reg <= '0;
            row_one_back_reg <= '0;
            row_cnt_reg      <= '0;
        end else begin
            row_two_back_reg <= row_two_back_next;
            row_one_back_reg <= row_one_back_next;
            row_cnt_reg      <= row_cnt_next;
        end
    end

    // ---------------------------------------------------------------
    // Input register: snapshot of the 3-row window for one request.
    // ---------------------------------------------------------------
    logic           s1_valid_reg;
    logic [W-1:0]   s1_above_reg, s1_mid_reg, s1_below_reg;
    logic [IW-1:0]  s1_row_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= in_fire;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            s1_above_reg <= row_two_back_reg;
            s1_mid_reg   <= row_one_back_reg;
            s1_below_reg <= cur_row;
            s1_row_reg   <= row_cnt_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stencil: new value of the middle row
    // ---------------------------------------------------------------
    logic [W-1:0] stencil_row;

    lgrs_stencil #(
        .COLS (COLS)
    ) u_stencil (
        .above    (s1_above_reg),
        .mid      (s1_mid_reg),
        .below    (s1_below_reg),
        .rule     (rule_reg),
        .next_row (stencil_row)
    );

    // ---------------------------------------------------------------
    // Result selection per arriving row r:
    //   r = 0       -> zero row 0
    //   r = 1       -> nothing
    //   r >= 2      -> new row r-1
    //   r = ROWS-1  -> also zero row r, flagged last
    // ---------------------------------------------------------------
    lgrs_pkg::push_t push;

    always_comb begin
        push.count  = 2'd0;
        push.first  = '0;
        push.second = '0;
        if (s1_valid_reg) begin
            if (s1_row_reg == '0) begin
                push.count = 2'd1;
            end else if (s1_row_reg != IW'(1)) begin
                push.first.next_cells = stencil_row;
                push.first.row_index  = s1_row_reg - IW'(1);
                push.second.last      = 1'b1;
                push.second.row_index = s1_row_reg;
                push.count = (s1_row_reg == LAST_ROW) ? 2'd2 : 2'd1;
            end
        end
    end

    // ---------------------------------------------------------------
    // Result queue and output
    // ---------------------------------------------------------------
    lgrs_pkg::res_t head;
    logic [QCW-1:0] q_count;
    logic           out_fire;

    assign out_fire = m_tvalid && m_tready;

    lgrs_fifo #(
        .DEPTH (DEPTH)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (out_fire),
        .head    (head),
        .count   (q_count)
    );

    // Reserve room for two results from the request in the input register
    // and two from the one about to be taken.
    assign s_tready = (q_count <= (s1_valid_reg ? QCW'(DEPTH - 4) : QCW'(DEPTH - 2)));

    assign m_tvalid = (q_count != '0);
    assign m_tdata  = {2'b00, head.row_index, head.next_cells};
    assign m_tlast  = head.last;

`ifndef SYNTHESIS
    // the last row of a grid is all dead and carries the final index
    a_last_row: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[63:0] == '0 && m_tdata[69:64] == LAST_ROW)
        else $error("last result is not the dead final row");

    a_row_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        row_cnt_reg <= LAST_ROW)
        else $error("row counter past last row");

    // finishing a grid clears the window
    a_wrap_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && row_cnt_reg == LAST_ROW |=>
            row_cnt_reg == '0 && row_one_back_reg == '0 && row_two_back_reg == '0)
        else $error("window not cleared at end of grid");

    // the lowest and highest columns stay dead in every result
    a_border_col: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !m_tdata[0] && !m_tdata[W-1])
        else $error("border column alive");

    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_count <= QCW'(DEPTH))
        else $error("result queue overflow");
`endif

endmodule
